FILE: rtl/core/cbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CBOR descriptor decoder package
// Shared payload types, result codes and encoding constants.
// ----------------------------------------------------------------------------
package cbd_pkg;

   typedef enum logic [1:0] {
      KIND_VALUE  = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FORMAT = 2'd1,
      STATUS_SIZE   = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] field_key;
      logic [5:0] byte_index;
      logic [63:0] field_value;
      status_type status_code;
      logic       final_flag;
   } rsp_type;

   // Results raised by one accepted byte: an optional field result, then an
   // optional final status.
   typedef struct packed {
      logic    data_valid;
      rsp_type data;
      logic    stat_valid;
      rsp_type stat;
   } emit_type;

   localparam logic [2:0] MAJOR_UINT  = 3'd0;
   localparam logic [2:0] MAJOR_BYTES = 3'd2;
   localparam logic [2:0] MAJOR_MAP   = 3'd5;

   localparam logic [4:0] AI_ONE      = 5'd24;
   localparam logic [4:0] AI_TWO      = 5'd25;
   localparam logic [4:0] AI_FOUR     = 5'd26;
   localparam logic [4:0] AI_RESERVED = 5'd28;

   localparam logic [3:0]  ENTRY_COUNT = 4'd11;
   localparam logic [11:0] ALL_KEYS    = 12'hFFE;

   localparam logic [3:0] KEY_FOUNDER   = 4'd1;
   localparam logic [3:0] KEY_NAME      = 4'd2;
   localparam logic [3:0] KEY_SYMBOL    = 4'd3;
   localparam logic [3:0] KEY_WORD_A    = 4'd5;
   localparam logic [3:0] KEY_FLAG      = 4'd6;
   localparam logic [3:0] KEY_HALF      = 4'd7;
   localparam logic [3:0] KEY_WORD_B    = 4'd8;
   localparam logic [3:0] KEY_GENESIS   = 4'd10;
   localparam logic [3:0] KEY_SIGNATURE = 4'd11;

endpackage

FILE: rtl/core/cbd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CBOR descriptor parser
// Holds the parse state and decodes one message byte per transfer.
// ----------------------------------------------------------------------------
module cbd_parser
   import cbd_pkg::*;
#(
   parameter int FOUNDER_KEY_BYTES = 64,
   parameter int NAME_CAPACITY     = 32,
   parameter int SYMBOL_CAPACITY   = 8,
   parameter int GENESIS_BYTES     = 32,
   parameter int SIGNATURE_BYTES   = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req,
   output emit_type emit
);

   typedef enum logic [2:0] {
      PH_MAP, PH_KEY, PH_VAL, PH_STR, PH_DONE, PH_SWALLOW
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_left_ff, hdr_left_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  cur_key_ff, cur_key_in;
   logic [6:0]  str_left_ff, str_left_in;
   logic [5:0]  str_pos_ff, str_pos_in;
   logic [3:0]  entries_ff, entries_in;
   logic [11:0] keys_ff, keys_in;
   logic [31:0] currency_ff, currency_in;

   logic [7:0]  b;
   logic [2:0]  major;
   logic [4:0]  ai;
   logic [2:0]  exp_major;
   logic [63:0] acc_shift;
   logic [3:0]  entries_inc;
   phase_type   entry_phase;
   logic        is_str_key;
   logic        hd_fire;
   logic [63:0] hd_v;
   status_type  err;
   logic        restart;

   assign b           = req.data_byte;
   assign major       = b[7:5];
   assign ai          = b[4:0];
   assign acc_shift   = {acc_ff[55:0], b};
   assign entries_inc = entries_ff + 4'd1;
   assign entry_phase = (entries_inc >= ENTRY_COUNT) ? PH_DONE : PH_KEY;
   assign is_str_key  = (cur_key_ff == KEY_FOUNDER) || (cur_key_ff == KEY_NAME) ||
                        (cur_key_ff == KEY_SYMBOL) || (cur_key_ff == KEY_GENESIS) ||
                        (cur_key_ff == KEY_SIGNATURE);

   always_comb begin
      priority if (phase_ff == PH_MAP) begin
         exp_major = MAJOR_MAP;
      end else if (phase_ff == PH_KEY) begin
         exp_major = MAJOR_UINT;
      end else if (is_str_key) begin
         exp_major = MAJOR_BYTES;
      end else begin
         exp_major = MAJOR_UINT;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      hdr_left_in = hdr_left_ff;
      acc_in      = acc_ff;
      cur_key_in  = cur_key_ff;
      str_left_in = str_left_ff;
      str_pos_in  = str_pos_ff;
      entries_in  = entries_ff;
      keys_in     = keys_ff;
      currency_in = currency_ff;
      emit        = '0;
      hd_fire     = 1'b0;
      hd_v        = '0;
      err         = STATUS_OK;
      restart     = 1'b0;

      if (phase_ff == PH_SWALLOW) begin
         restart = req.last_byte;
      end else begin
         priority if (phase_ff == PH_DONE) begin
            err = STATUS_FORMAT;
         end else if (phase_ff == PH_STR) begin
            emit.data_valid      = 1'b1;
            emit.data.kind       = KIND_BYTE;
            emit.data.field_key  = cur_key_ff;
            emit.data.byte_index = str_pos_ff;
            emit.data.field_value = {56'd0, b};
            if ((cur_key_ff == KEY_GENESIS) && (str_pos_ff < 6'd4)) begin
               currency_in = {currency_ff[23:0], b};
            end
            str_pos_in  = str_pos_ff + 6'd1;
            str_left_in = str_left_ff - 7'd1;
            if (str_left_ff == 7'd1) begin
               entries_in = entries_inc;
               phase_in   = entry_phase;
            end
         end else if (hdr_left_ff != 4'd0) begin
            acc_in      = acc_shift;
            hdr_left_in = hdr_left_ff - 4'd1;
            if (hdr_left_ff == 4'd1) begin
               hd_fire = 1'b1;
               hd_v    = acc_shift;
            end
         end else if ((major != exp_major) || (ai >= AI_RESERVED)) begin
            err = STATUS_FORMAT;
         end else if (ai < AI_ONE) begin
            hd_fire = 1'b1;
            hd_v    = 64'(ai);
         end else begin
            acc_in = '0;
            priority if (ai == AI_ONE) begin
               hdr_left_in = 4'd1;
            end else if (ai == AI_TWO) begin
               hdr_left_in = 4'd2;
            end else if (ai == AI_FOUR) begin
               hdr_left_in = 4'd4;
            end else begin
               hdr_left_in = 4'd8;
            end
         end

         if (hd_fire) begin
            priority if (phase_ff == PH_MAP) begin
               if (hd_v != 64'(ENTRY_COUNT)) begin
                  err = STATUS_FORMAT;
               end else begin
                  entries_in = '0;
                  phase_in   = PH_KEY;
               end
            end else if (phase_ff == PH_KEY) begin
               if ((hd_v < 64'd1) || (hd_v > 64'(ENTRY_COUNT))) begin
                  err = STATUS_FORMAT;
               end else begin
                  cur_key_in = hd_v[3:0];
                  keys_in    = keys_ff | (12'd1 << hd_v[3:0]);
                  phase_in   = PH_VAL;
               end
            end else if (is_str_key) begin
               priority if (cur_key_ff == KEY_FOUNDER) begin
                  if (hd_v != 64'(FOUNDER_KEY_BYTES)) err = STATUS_SIZE;
               end else if (cur_key_ff == KEY_GENESIS) begin
                  if (hd_v != 64'(GENESIS_BYTES)) err = STATUS_SIZE;
               end else if (cur_key_ff == KEY_SIGNATURE) begin
                  if (hd_v != 64'(SIGNATURE_BYTES)) err = STATUS_SIZE;
               end else if (cur_key_ff == KEY_NAME) begin
                  if (hd_v >= 64'(NAME_CAPACITY)) err = STATUS_SIZE;
               end else begin
                  if (hd_v >= 64'(SYMBOL_CAPACITY)) err = STATUS_SIZE;
               end
               if (err == STATUS_OK) begin
                  if (hd_v == 64'd0) begin
                     entries_in = entries_inc;
                     phase_in   = entry_phase;
                  end else begin
                     str_left_in = hd_v[6:0];
                     str_pos_in  = '0;
                     phase_in    = PH_STR;
                  end
               end
            end else begin
               priority if (((cur_key_ff == KEY_WORD_A) || (cur_key_ff == KEY_WORD_B)) &&
                            (hd_v[63:32] != 32'd0)) begin
                  err = STATUS_FORMAT;
               end else if ((cur_key_ff == KEY_FLAG) && (hd_v > 64'd1)) begin
                  err = STATUS_FORMAT;
               end else if ((cur_key_ff == KEY_HALF) && (hd_v[63:16] != 48'd0)) begin
                  err = STATUS_FORMAT;
               end else begin
                  emit.data_valid       = 1'b1;
                  emit.data.kind        = KIND_VALUE;
                  emit.data.field_key   = cur_key_ff;
                  emit.data.field_value = hd_v;
                  entries_in = entries_inc;
                  phase_in   = entry_phase;
               end
            end
         end

         if ((err == STATUS_OK) && req.last_byte) begin
            priority if (phase_in != PH_DONE) begin
               err = STATUS_SIZE;
            end else if ((keys_in & ALL_KEYS) != ALL_KEYS) begin
               err = STATUS_FORMAT;
            end else begin
               emit.stat_valid       = 1'b1;
               emit.stat.kind        = KIND_STATUS;
               emit.stat.field_value = {32'd0, currency_in};
               emit.stat.status_code = STATUS_OK;
               emit.stat.final_flag  = 1'b1;
               restart = 1'b1;
            end
         end

         if (err != STATUS_OK) begin
            emit.stat_valid       = 1'b1;
            emit.stat.kind        = KIND_STATUS;
            emit.stat.status_code = err;
            emit.stat.final_flag  = 1'b1;
            if (req.last_byte) begin
               restart = 1'b1;
            end else begin
               phase_in = PH_SWALLOW;
            end
         end
      end

      if (restart) begin
         phase_in    = PH_MAP;
         hdr_left_in = '0;
         acc_in      = '0;
         cur_key_in  = '0;
         str_left_in = '0;
         str_pos_in  = '0;
         entries_in  = '0;
         keys_in     = '0;
         currency_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAP;
         hdr_left_ff <= '0;
         acc_ff      <= '0;
         cur_key_ff  <= '0;
         str_left_ff <= '0;
         str_pos_ff  <= '0;
         entries_ff  <= '0;
         keys_ff     <= '0;
         currency_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hdr_left_ff <= hdr_left_in;
         acc_ff      <= acc_in;
         cur_key_ff  <= cur_key_in;
         str_left_ff <= str_left_in;
         str_pos_ff  <= str_pos_in;
         entries_ff  <= entries_in;
         keys_ff     <= keys_in;
         currency_ff <= currency_in;
      end
   end

endmodule

FILE: rtl/core/cbd_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CBOR descriptor result queue
// Four-entry queue that takes up to two results per transfer and
// presents one result per cycle on the output channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module cbd_rsp_queue
   import cbd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  emit_type emit,
   output logic     full,
   output logic [2:0] count,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   rsp_type    mem_ff [4];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] wr_next;
   logic [1:0] n_push;
   logic       pop;
   rsp_type    first;

   assign n_push  = push ? (2'(emit.data_valid) + 2'(emit.stat_valid)) : 2'd0;
   assign pop     = (count_ff != 3'd0) && !rsp_stall;
   assign wr_next = wr_ptr_ff + 2'd1;
   assign first   = emit.data_valid ? emit.data : emit.stat;

   assign rd_ptr_in = rd_ptr_ff + 2'(pop);
   assign wr_ptr_in = wr_ptr_ff + n_push;
   assign count_in  = count_ff + 3'(n_push) - 3'(pop);

   assign full        = count_ff > 3'd2;
   assign count       = count_ff;
   assign rsp_valid   = count_ff != 3'd0;
   assign rsp_payload = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= first;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_next] <= emit.stat;
      end
   end

endmodule

FILE: rtl/core/cbor_descriptor_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CBOR descriptor decoder
// Streaming decoder for an eleven-entry CBOR map descriptor.
// ----------------------------------------------------------------------------
// One message byte is taken per cycle. Each accepted byte is decoded against
// the parse state in the same cycle and its results, at most two, enter a
// four-entry result queue; they appear on the result channel from the next
// cycle. The result queue drains one result per cycle while rsp_stall is
// low, so a byte that raises two results (the final byte of a field and the
// end-of-message status) needs two transfers; the input stalls while more
// than two results are queued. After an error status the remaining bytes
// of the message are consumed without results up to the byte marked last.
module cbor_descriptor_decoder
   import cbd_pkg::*;
#(
   parameter int FOUNDER_KEY_BYTES = 64,
   parameter int NAME_CAPACITY     = 32,
   parameter int SYMBOL_CAPACITY   = 8,
   parameter int GENESIS_BYTES     = 32,
   parameter int SIGNATURE_BYTES   = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic       accept;
   logic       full;
   logic [2:0] count;
   emit_type   emit;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   cbd_parser #(
      .FOUNDER_KEY_BYTES(FOUNDER_KEY_BYTES),
      .NAME_CAPACITY    (NAME_CAPACITY),
      .SYMBOL_CAPACITY  (SYMBOL_CAPACITY),
      .GENESIS_BYTES    (GENESIS_BYTES),
      .SIGNATURE_BYTES  (SIGNATURE_BYTES)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_payload),
      .emit  (emit)
   );

   cbd_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .emit       (emit),
      .full       (full),
      .count      (count),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count <= 3'd4)
      else $error("Result queue occupancy out of range.");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      accept && emit.stat_valid |-> emit.stat.final_flag && (emit.stat.kind == KIND_STATUS))
      else $error("Status result without final flag.");

   a_field_not_final: assert property (@(posedge clock) disable iff (reset)
      accept && emit.data_valid |-> !emit.data.final_flag && (emit.data.kind != KIND_STATUS))
      else $error("Field result marked as status.");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !accept |=> count == $past(count) - 3'd1)
      else $error("Result queue did not drain on transfer.");

endmodule

FILE: tb/tb_cbor_descriptor_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CBOR descriptor decoder testbench
// Streams short directed byte sequences, then mostly well-formed descriptor
// messages with random content and random flaws (truncation, trailing bytes,
// corrupted bytes, repeated keys, bad values), mixed with noise. Every byte
// transfer is run through a cycle-free decoder in the bench, and each result
// transfer is compared field by field with the oldest expected result.
// Both channels idle at random in the first two of three phases; in the last
// the result side holds off for a long stretch once so the input backs up.
// ----------------------------------------------------------------------------
module tb_cbor_descriptor_decoder;
   import cbd_pkg::*;

   localparam int FOUNDER_LEN   = 64;
   localparam int NAME_CAP      = 32;
   localparam int SYMBOL_CAP    = 8;
   localparam int GENESIS_LEN   = 32;
   localparam int SIGNATURE_LEN = 64;

   localparam logic [4:0] AI_EIGHT = 5'd27;

   localparam int RANDOM_ITEMS  = 550;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 16;
   localparam int DIRECTED_ROWS = 25;

   typedef enum logic [2:0] {
      P_MAP,
      P_KEY,
      P_VALUE,
      P_STRING,
      P_COMPLETE,
      P_DISCARD
   } parse_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       known;
      status_type code;
   } directed_row_type;

   // Rows marked known carry the single status result they must raise.
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, STATUS_FORMAT},
      '{8'hBC, 1'b1, 1'b1, STATUS_FORMAT},
      '{8'hA0, 1'b1, 1'b1, STATUS_FORMAT},
      '{8'hBF, 1'b0, 1'b1, STATUS_FORMAT},
      '{8'h55, 1'b0, 1'b0, STATUS_OK},
      '{8'hFF, 1'b1, 1'b0, STATUS_OK},
      '{8'hAB, 1'b1, 1'b1, STATUS_SIZE},
      '{8'hB8, 1'b0, 1'b0, STATUS_OK},
      '{8'h0B, 1'b0, 1'b0, STATUS_OK},
      '{8'h0C, 1'b0, 1'b1, STATUS_FORMAT},
      '{8'h00, 1'b1, 1'b0, STATUS_OK},
      '{8'hAB, 1'b0, 1'b0, STATUS_OK},
      '{8'h04, 1'b0, 1'b0, STATUS_OK},
      '{8'h1B, 1'b0, 1'b0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{8'hFF, 1'b1, 1'b0, STATUS_OK},
      '{8'hAB, 1'b0, 1'b0, STATUS_OK},
      '{8'h03, 1'b0, 1'b0, STATUS_OK},
      '{8'h48, 1'b1, 1'b1, STATUS_SIZE}
   };

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   parse_state_type dec_phase;
   logic [3:0]   head_left;
   logic [63:0]  head_value;
   logic [3:0]   cur_key;
   logic [6:0]   str_left;
   logic [5:0]   str_pos;
   logic [3:0]   entry_count;
   logic [11:0]  keys_seen;
   logic [31:0]  currency;

   rsp_type decoded[$];
   rsp_type pending_results[$];
   req_type outgoing[$];

   int req_idle_pct = 17;
   int rsp_idle_pct = 59;
   int hold_asked   = 0;
   int hold_served  = 0;
   int hold_left    = 0;
   int mismatches   = 0;
   int cycle_count  = 0;
   int counted      = 0;

   cbor_descriptor_decoder #(
      .FOUNDER_KEY_BYTES(FOUNDER_LEN),
      .NAME_CAPACITY(NAME_CAP),
      .SYMBOL_CAPACITY(SYMBOL_CAP),
      .GENESIS_BYTES(GENESIS_LEN),
      .SIGNATURE_BYTES(SIGNATURE_LEN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_type make_rsp(kind_type k, logic [3:0] key, logic [5:0] idx,
                                        logic [63:0] v, status_type code, logic fin);
      rsp_type r;
      r.kind        = k;
      r.field_key   = key;
      r.byte_index  = idx;
      r.field_value = v;
      r.status_code = code;
      r.final_flag  = fin;
      return r;
   endfunction

   function automatic logic [63:0] value_limit(logic [3:0] key);
      case (key)
         KEY_WORD_A, KEY_WORD_B: return 64'hFFFF_FFFF;
         KEY_FLAG:               return 64'd1;
         KEY_HALF:               return 64'hFFFF;
         default:                return '1;
      endcase
   endfunction

   function automatic int length_bound(logic [3:0] key);
      case (key)
         KEY_FOUNDER:   return FOUNDER_LEN;
         KEY_NAME:      return NAME_CAP;
         KEY_SYMBOL:    return SYMBOL_CAP;
         KEY_GENESIS:   return GENESIS_LEN;
         KEY_SIGNATURE: return SIGNATURE_LEN;
         default:       return 0;
      endcase
   endfunction

   function automatic logic is_fixed_string(logic [3:0] key);
      return key == KEY_FOUNDER || key == KEY_GENESIS || key == KEY_SIGNATURE;
   endfunction

   function automatic logic is_text_string(logic [3:0] key);
      return key == KEY_NAME || key == KEY_SYMBOL;
   endfunction

   function automatic logic [2:0] wanted_major();
      if (dec_phase == P_MAP) return MAJOR_MAP;
      if (dec_phase == P_KEY) return MAJOR_UINT;
      if (is_fixed_string(cur_key) || is_text_string(cur_key)) return MAJOR_BYTES;
      return MAJOR_UINT;
   endfunction

   task automatic clear_parse();
      dec_phase   = P_MAP;
      head_left   = '0;
      head_value  = '0;
      cur_key     = '0;
      str_left    = '0;
      str_pos     = '0;
      entry_count = '0;
      keys_seen   = '0;
      currency    = '0;
   endtask

   task automatic close_entry();
      entry_count = entry_count + 4'd1;
      dec_phase   = (entry_count >= ENTRY_COUNT) ? P_COMPLETE : P_KEY;
   endtask

   task automatic finish_head(output status_type err);
      logic is_string;
      err       = STATUS_OK;
      is_string = 1'b1;
      case (dec_phase)
         P_MAP: begin
            if (head_value != 64'(ENTRY_COUNT)) begin
               err = STATUS_FORMAT;
            end else begin
               entry_count = '0;
               dec_phase   = P_KEY;
            end
         end
         P_KEY: begin
            if (head_value < 64'd1 || head_value > 64'(ENTRY_COUNT)) begin
               err = STATUS_FORMAT;
            end else begin
               cur_key   = head_value[3:0];
               keys_seen = keys_seen | (12'd1 << cur_key);
               dec_phase = P_VALUE;
            end
         end
         default: begin
            if (is_fixed_string(cur_key)) begin
               if (head_value != 64'(length_bound(cur_key))) err = STATUS_SIZE;
            end else if (is_text_string(cur_key)) begin
               if (head_value >= 64'(length_bound(cur_key))) err = STATUS_SIZE;
            end else begin
               is_string = 1'b0;
               if (head_value > value_limit(cur_key)) begin
                  err = STATUS_FORMAT;
               end else begin
                  decoded.push_back(make_rsp(KIND_VALUE, cur_key, 6'd0, head_value,
                                             STATUS_OK, 1'b0));
                  close_entry();
               end
            end
            if (is_string && err == STATUS_OK) begin
               if (head_value == 64'd0) begin
                  close_entry();
               end else begin
                  str_left  = head_value[6:0];
                  str_pos   = '0;
                  dec_phase = P_STRING;
               end
            end
         end
      endcase
   endtask

   task automatic take_byte(input logic [7:0] b, output status_type err);
      err = STATUS_OK;
      if (dec_phase == P_COMPLETE) begin
         err = STATUS_FORMAT;
      end else if (dec_phase == P_STRING) begin
         decoded.push_back(make_rsp(KIND_BYTE, cur_key, str_pos, 64'(b), STATUS_OK, 1'b0));
         if (cur_key == KEY_GENESIS && str_pos < 6'd4) currency = {currency[23:0], b};
         str_pos  = str_pos + 6'd1;
         str_left = str_left - 7'd1;
         if (str_left == 7'd0) close_entry();
      end else if (head_left != 4'd0) begin
         head_value = {head_value[55:0], b};
         head_left  = head_left - 4'd1;
         if (head_left == 4'd0) finish_head(err);
      end else if (b[7:5] != wanted_major() || b[4:0] >= AI_RESERVED) begin
         err = STATUS_FORMAT;
      end else if (b[4:0] < AI_ONE) begin
         head_value = 64'(b[4:0]);
         finish_head(err);
      end else begin
         head_value = '0;
         case (b[4:0])
            AI_ONE:  head_left = 4'd1;
            AI_TWO:  head_left = 4'd2;
            AI_FOUR: head_left = 4'd4;
            default: head_left = 4'd8;
         endcase
      end
   endtask

   task automatic decode_byte(input req_type p);
      status_type err;
      decoded.delete();
      if (dec_phase == P_DISCARD) begin
         if (p.last_byte) clear_parse();
      end else begin
         take_byte(p.data_byte, err);
         if (err == STATUS_OK && p.last_byte) begin
            if (dec_phase != P_COMPLETE) begin
               err = STATUS_SIZE;
            end else if ((keys_seen & ALL_KEYS) != ALL_KEYS) begin
               err = STATUS_FORMAT;
            end else begin
               decoded.push_back(make_rsp(KIND_STATUS, 4'd0, 6'd0, 64'(currency),
                                          STATUS_OK, 1'b1));
               clear_parse();
            end
         end
         if (err != STATUS_OK) begin
            decoded.push_back(make_rsp(KIND_STATUS, 4'd0, 6'd0, 64'd0, err, 1'b1));
            if (p.last_byte) clear_parse();
            else dec_phase = P_DISCARD;
         end
      end
   endtask

   task automatic drive_byte(input req_type p, input logic known, input status_type code);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      counted++;
      decode_byte(p);
      if (known) begin
         pending_results.push_back(make_rsp(KIND_STATUS, 4'd0, 6'd0, 64'd0, code, 1'b1));
      end else begin
         foreach (decoded[i]) pending_results.push_back(decoded[i]);
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      outgoing.push_back(req_type'{data_byte: b, last_byte: 1'b0});
   endtask

   task automatic push_random(input int count);
      repeat (count) push_byte(8'($urandom_range(255)));
   endtask

   task automatic put_head(input logic [2:0] major, input logic [63:0] v);
      int minimal;
      int form;
      int nb;
      if (v < 64'd24) minimal = 0;
      else if (v <= 64'hFF) minimal = 1;
      else if (v <= 64'hFFFF) minimal = 2;
      else if (v <= 64'hFFFF_FFFF) minimal = 3;
      else minimal = 4;
      form = ($urandom_range(3) != 0) ? minimal : $urandom_range(4, minimal);
      case (form)
         0: begin
            push_byte({major, v[4:0]});
            nb = 0;
         end
         1: begin
            push_byte({major, AI_ONE});
            nb = 1;
         end
         2: begin
            push_byte({major, AI_TWO});
            nb = 2;
         end
         3: begin
            push_byte({major, AI_FOUR});
            nb = 4;
         end
         default: begin
            push_byte({major, AI_EIGHT});
            nb = 8;
         end
      endcase
      for (int i = nb - 1; i >= 0; i--) push_byte(v[8*i +: 8]);
   endtask

   task automatic put_int(input logic [3:0] key, input logic bad);
      logic [63:0] limit;
      logic [63:0] v;
      limit = value_limit(key);
      if (bad && limit == '1) begin
         push_byte({MAJOR_UINT, 5'(AI_RESERVED + $urandom_range(3))});
      end else begin
         if (bad) begin
            v = limit + 64'd1 + 64'($urandom_range(1000));
         end else begin
            case ($urandom_range(3))
               0:       v = '0;
               1:       v = limit;
               2:       v = 64'($urandom_range(30));
               default: v = {$urandom, $urandom};
            endcase
            v = v & limit;
         end
         put_head(MAJOR_UINT, v);
      end
   endtask

   task automatic mark_last();
      req_type tail;
      tail = outgoing.pop_back();
      tail.last_byte = 1'b1;
      outgoing.push_back(tail);
   endtask

   task automatic build_message();
      int      flaw;
      int      bad_slot;
      int      order [11];
      int      j;
      int      held_key;
      int      len;
      int      cut;
      int      pos;
      logic    bad;
      logic    stop;
      req_type hit;
      outgoing.delete();
      flaw     = $urandom_range(9);
      bad_slot = $urandom_range(10);
      for (int i = 0; i < 11; i++) order[i] = i + 1;
      for (int i = 10; i > 0; i--) begin
         j        = $urandom_range(i);
         held_key = order[i];
         order[i] = order[j];
         order[j] = held_key;
      end
      if (flaw == 8) order[$urandom_range(10)] = order[$urandom_range(10)];
      put_head(MAJOR_MAP, 64'(ENTRY_COUNT));
      stop = 1'b0;
      for (int i = 0; i < 11 && !stop; i++) begin
         bad = (flaw == 9 && i == bad_slot);
         put_head(MAJOR_UINT, 64'(order[i]));
         if (is_fixed_string(4'(order[i])) || is_text_string(4'(order[i]))) begin
            len = length_bound(4'(order[i]));
            if (is_fixed_string(4'(order[i]))) begin
               if (bad) len = (len > 1 && $urandom_range(1)) ? $urandom_range(len - 1)
                                                             : len + $urandom_range(8, 1);
            end else begin
               len = bad ? $urandom_range(64, len) : $urandom_range(len - 1);
            end
            put_head(MAJOR_BYTES, 64'(len));
            if (!bad) push_random(len);
         end else begin
            put_int(4'(order[i]), bad);
         end
         if (bad) begin
            push_random($urandom_range(3));
            stop = 1'b1;
         end
      end
      if (flaw == 6) push_random($urandom_range(3, 1));
      if (flaw == 5) begin
         cut = $urandom_range(outgoing.size() - 1, 1);
         while (outgoing.size() > cut) void'(outgoing.pop_back());
      end
      if (flaw == 7) begin
         pos           = $urandom_range(outgoing.size() - 1);
         hit           = outgoing[pos];
         hit.data_byte = 8'($urandom_range(255));
         outgoing[pos] = hit;
      end
      mark_last();
   endtask

   task automatic build_noise();
      req_type p;
      outgoing.delete();
      repeat ($urandom_range(6, 1)) begin
         p.data_byte = 8'($urandom_range(255));
         p.last_byte = ($urandom_range(3) == 0);
         outgoing.push_back(p);
      end
      mark_last();
   endtask

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer: kind %0d key %0d value %0h",
                   rsp_payload.kind, rsp_payload.field_key, rsp_payload.field_value);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            report_field("kind", 64'(want.kind), 64'(rsp_payload.kind));
            report_field("field_key", 64'(want.field_key), 64'(rsp_payload.field_key));
            report_field("byte_index", 64'(want.byte_index), 64'(rsp_payload.byte_index));
            report_field("field_value", want.field_value, rsp_payload.field_value);
            report_field("status_code", 64'(want.status_code), 64'(rsp_payload.status_code));
            report_field("final_flag", 64'(want.final_flag), 64'(rsp_payload.final_flag));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic held;
      held = 1'b0;
      clear_parse();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_table[i]) begin
         drive_byte(req_type'{data_byte: directed_table[i].data,
                              last_byte: directed_table[i].last},
                    directed_table[i].known, directed_table[i].code);
      end
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted < RANDOM_ITEMS / 3) begin
            req_idle_pct = 17;
            rsp_idle_pct = 59;
         end else if (counted < 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 59;
            rsp_idle_pct = 17;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            if (!held) begin
               held = 1'b1;
               hold_asked++;
            end
         end
         if ($urandom_range(99) < 15) build_noise();
         else build_message();
         foreach (outgoing[i]) begin
            if (counted < RANDOM_ITEMS) drive_byte(outgoing[i], 1'b0, STATUS_OK);
         end
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: cbor_descriptor_decoder.f
rtl/core/cbd_pkg.sv
rtl/core/cbd_parser.sv
rtl/core/cbd_rsp_queue.sv
rtl/core/cbor_descriptor_decoder.sv
tb/tb_cbor_descriptor_decoder.sv
